// ===== rtl/skl_pkg.sv =====
// shared types, constants and keyword lookup for the streaming keyword lexer
package skl_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int FIELD_BITS  = 16;
  localparam int MAX_KW_LEN  = 8;
  localparam int KW_LEN_BITS = $clog2(MAX_KW_LEN + 2);
  localparam int KW_IDX_BITS = $clog2(MAX_KW_LEN);
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_INT     = 3'd2,
    MODE_FRAC    = 3'd3,
    MODE_SLASH   = 3'd4,
    MODE_COMMENT = 3'd5
  } scan_mode_t;

  typedef enum logic [4:0] {
    KIND_IDENT      = 5'd0,
    KIND_INT        = 5'd1,
    KIND_FLOAT      = 5'd2,
    KIND_KW_MAP     = 5'd3,
    KIND_KW_ENEMY   = 5'd4,
    KIND_KW_TOWER   = 5'd5,
    KIND_KW_WAVE    = 5'd6,
    KIND_KW_SPAWN   = 5'd7,
    KIND_KW_PLACE   = 5'd8,
    KIND_KW_AT      = 5'd9,
    KIND_KW_SIZE    = 5'd10,
    KIND_KW_PATH    = 5'd11,
    KIND_KW_COUNT   = 5'd12,
    KIND_KW_START   = 5'd13,
    KIND_KW_INTERVAL = 5'd14,
    KIND_LBRACE     = 5'd15,
    KIND_RBRACE     = 5'd16,
    KIND_LPAREN     = 5'd17,
    KIND_RPAREN     = 5'd18,
    KIND_LBRACKET   = 5'd19,
    KIND_RBRACKET   = 5'd20,
    KIND_COMMA      = 5'd21,
    KIND_SEMI       = 5'd22,
    KIND_ASSIGN     = 5'd23,
    KIND_PLUS       = 5'd24,
    KIND_MINUS      = 5'd25,
    KIND_STAR       = 5'd26,
    KIND_DIV        = 5'd27,
    KIND_UNKNOWN    = 5'd28,
    KIND_EOF        = 5'd29
  } token_kind_t;

  typedef logic [MAX_KW_LEN-1:0][7:0] prefix_t;

  typedef struct packed {
    token_kind_t            kind;
    logic [FIELD_BITS-1:0]  start;
    logic [FIELD_BITS-1:0]  length;
    logic [FIELD_BITS-1:0]  line;
    logic [7:0]             bval;
    logic                   run_end;
  } token_t;

  function automatic token_kind_t ident_kind(input prefix_t p,
                                             input logic [KW_LEN_BITS-1:0] len);
    token_kind_t k;
    k = KIND_IDENT;
    case (len)
      KW_LEN_BITS'(2): begin
        if ({p[0], p[1]} == "at") k = KIND_KW_AT;
      end
      KW_LEN_BITS'(3): begin
        if ({p[0], p[1], p[2]} == "map") k = KIND_KW_MAP;
      end
      KW_LEN_BITS'(4): begin
        if ({p[0], p[1], p[2], p[3]} == "wave") k = KIND_KW_WAVE;
        if ({p[0], p[1], p[2], p[3]} == "size") k = KIND_KW_SIZE;
        if ({p[0], p[1], p[2], p[3]} == "path") k = KIND_KW_PATH;
      end
      KW_LEN_BITS'(5): begin
        if ({p[0], p[1], p[2], p[3], p[4]} == "enemy") k = KIND_KW_ENEMY;
        if ({p[0], p[1], p[2], p[3], p[4]} == "tower") k = KIND_KW_TOWER;
        if ({p[0], p[1], p[2], p[3], p[4]} == "spawn") k = KIND_KW_SPAWN;
        if ({p[0], p[1], p[2], p[3], p[4]} == "place") k = KIND_KW_PLACE;
        if ({p[0], p[1], p[2], p[3], p[4]} == "count") k = KIND_KW_COUNT;
        if ({p[0], p[1], p[2], p[3], p[4]} == "start") k = KIND_KW_START;
      end
      KW_LEN_BITS'(8): begin
        if ({p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]} == "interval")
          k = KIND_KW_INTERVAL;
      end
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction

  // one-character punctuators, slash excluded
  function automatic logic punct_hit(input logic [7:0] c);
    return (c == "{") || (c == "}") || (c == "(") || (c == ")") || (c == "[") ||
           (c == "]") || (c == ",") || (c == ";") || (c == "=") || (c == "+") ||
           (c == "-") || (c == "*");
  endfunction

  function automatic token_kind_t punct_kind(input logic [7:0] c);
    token_kind_t k;
    case (c)
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "[":     k = KIND_LBRACKET;
      "]":     k = KIND_RBRACKET;
      ",":     k = KIND_COMMA;
      ";":     k = KIND_SEMI;
      "=":     k = KIND_ASSIGN;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/skl_in_if.sv =====
// source byte channel of the keyword lexer
interface skl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_marker;

  modport source (output valid, output char_byte, output end_marker, input ready);
  modport sink (input valid, input char_byte, input end_marker, output ready);
endinterface

// ===== rtl/skl_out_if.sv =====
// token channel of the keyword lexer
interface skl_out_if;
  logic                               valid;
  logic                               ready;
  logic [4:0]                         token_kind;
  logic [skl_pkg::FIELD_BITS-1:0]     start_offset;
  logic [skl_pkg::FIELD_BITS-1:0]     token_length;
  logic [skl_pkg::FIELD_BITS-1:0]     line_number;
  logic [7:0]                         byte_value;
  logic                               run_end;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output line_number, output byte_value,
                  output run_end, input ready);
  modport sink (input valid, input token_kind, input start_offset,
                input token_length, input line_number, input byte_value,
                input run_end, output ready);
endinterface

// ===== rtl/streaming_keyword_lexer_core.sv =====
// Streaming keyword lexer top level: takes one source byte or end marker per
// transaction and emits tokens with kind, start offset, length and line.
// Each byte is lexed in the cycle it is accepted, so one transaction per clock
// is sustained while the queue has room; its tokens (none, one or two) go into
// a four-entry result queue that drives the token channel. The byte channel is
// ready while the queue has room for two tokens, so a byte that ends one token
// and yields another fills two entries; input waits while over two are queued.
// Identifiers are matched against the twelve keywords from an eight-byte prefix
// store in the cycle the identifier ends. Offset and line counters saturate.
module streaming_keyword_lexer_core (
  input  logic             clk,
  input  logic             rst,
  skl_in_if.sink           src,
  skl_out_if.source        tok
);

  skl_pkg::scan_mode_t                   mode;
  skl_pkg::scan_mode_t                   mode_next;
  skl_pkg::prefix_t                      prefix_store;
  logic [skl_pkg::KW_LEN_BITS-1:0]       ident_len;
  logic [skl_pkg::OFFSET_BITS-1:0]       token_start;
  logic [skl_pkg::OFFSET_BITS-1:0]       byte_offset;
  logic [skl_pkg::FIELD_BITS-1:0]        line_count;
  logic [skl_pkg::FIELD_BITS-1:0]        held_slash_line;

  skl_pkg::token_t                       fifo_mem [skl_pkg::FIFO_DEPTH];
  logic [skl_pkg::FIFO_PTR_BITS-1:0]     wr_ptr;
  logic [skl_pkg::FIFO_PTR_BITS-1:0]     rd_ptr;
  logic [skl_pkg::FIFO_CNT_BITS-1:0]     fifo_cnt;

  logic [7:0] c;
  logic       take;
  logic       is_end;
  logic       is_digit;
  logic       is_word_start;
  logic       is_word;
  logic       is_blank;
  logic       is_newline;
  logic       is_slash;
  logic       cont;
  logic       restart;

  logic            fin_valid;
  skl_pkg::token_t fin_tok;
  logic            b_valid;
  skl_pkg::token_t b_tok;
  logic            push_one;
  logic            push_two;
  logic            pop;

  assign c    = src.char_byte;
  assign take = src.valid && src.ready;
  assign is_end = src.end_marker;

  always_comb begin
    is_digit      = c inside {["0":"9"]};
    is_word_start = (c inside {["a":"z"], ["A":"Z"]}) || (c == "_");
    is_word       = is_word_start || is_digit;
    is_blank      = c inside {" ", 8'h09, 8'h0d};
    is_newline    = c == 8'h0a;
    is_slash      = c == "/";
  end

  // does the byte extend the current token
  always_comb begin
    case (mode)
      skl_pkg::MODE_IDENT:   cont = is_word;
      skl_pkg::MODE_INT:     cont = is_digit || (c == ".");
      skl_pkg::MODE_FRAC:    cont = is_digit;
      skl_pkg::MODE_SLASH:   cont = is_slash;
      skl_pkg::MODE_COMMENT: cont = !is_newline;
      default:               cont = 1'b0;
    endcase
  end

  assign restart = take && !is_end && !cont;

  // next scan mode
  always_comb begin
    mode_next = mode;
    if (take) begin
      if (is_end) begin
        mode_next = skl_pkg::MODE_IDLE;
      end else if (cont) begin
        if (mode == skl_pkg::MODE_INT && c == ".") mode_next = skl_pkg::MODE_FRAC;
        else if (mode == skl_pkg::MODE_SLASH) mode_next = skl_pkg::MODE_COMMENT;
      end else if (is_slash) begin
        mode_next = skl_pkg::MODE_SLASH;
      end else if (is_digit) begin
        mode_next = skl_pkg::MODE_INT;
      end else if (is_word_start) begin
        mode_next = skl_pkg::MODE_IDENT;
      end else begin
        mode_next = skl_pkg::MODE_IDLE;
      end
    end
  end

  // token outputs: pending token first, then new byte or eof
  always_comb begin
    fin_valid       = take && (is_end || !cont) &&
                      (mode == skl_pkg::MODE_IDENT || mode == skl_pkg::MODE_INT ||
                       mode == skl_pkg::MODE_FRAC || mode == skl_pkg::MODE_SLASH);
    fin_tok.start   = skl_pkg::FIELD_BITS'(token_start);
    fin_tok.length  = skl_pkg::FIELD_BITS'(byte_offset - token_start);
    fin_tok.line    = line_count;
    fin_tok.bval    = '0;
    fin_tok.run_end = 1'b0;
    case (mode)
      skl_pkg::MODE_IDENT: fin_tok.kind = skl_pkg::ident_kind(prefix_store, ident_len);
      skl_pkg::MODE_INT:   fin_tok.kind = skl_pkg::KIND_INT;
      skl_pkg::MODE_FRAC:  fin_tok.kind = skl_pkg::KIND_FLOAT;
      skl_pkg::MODE_SLASH: begin
        fin_tok.kind   = skl_pkg::KIND_DIV;
        fin_tok.length = skl_pkg::FIELD_BITS'(1);
        fin_tok.line   = held_slash_line;
      end
      default:             fin_tok.kind = skl_pkg::KIND_IDENT;
    endcase

    b_tok.run_end = 1'b1;
    b_tok.line    = line_count;
    b_tok.bval    = '0;
    if (is_end) begin
      b_valid      = take;
      b_tok.kind   = skl_pkg::KIND_EOF;
      b_tok.start  = skl_pkg::FIELD_BITS'(byte_offset);
      b_tok.length = '0;
    end else begin
      b_valid      = restart && !is_blank && !is_newline && !is_slash &&
                     !is_word && (c != "_");
      b_tok.start  = skl_pkg::FIELD_BITS'(byte_offset);
      b_tok.length = skl_pkg::FIELD_BITS'(1);
      if (skl_pkg::punct_hit(c)) begin
        b_tok.kind = skl_pkg::punct_kind(c);
      end else begin
        b_tok.kind = skl_pkg::KIND_UNKNOWN;
        b_tok.bval = c;
      end
    end
    fin_tok.run_end = !b_valid;
  end

  assign push_one = fin_valid || b_valid;
  assign push_two = fin_valid && b_valid;
  assign pop      = tok.valid && tok.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= skl_pkg::MODE_IDLE;
      ident_len       <= '0;
      token_start     <= '0;
      byte_offset     <= '0;
      line_count      <= skl_pkg::FIELD_BITS'(1);
      held_slash_line <= '0;
    end else begin
      mode <= mode_next;
      if (take && !is_end) begin
        if (byte_offset != '1) byte_offset <= byte_offset + 1'b1;
        if (cont && mode == skl_pkg::MODE_IDENT &&
            ident_len <= skl_pkg::KW_LEN_BITS'(skl_pkg::MAX_KW_LEN))
          ident_len <= ident_len + 1'b1;
        if (restart) begin
          if (is_newline && line_count != '1) line_count <= line_count + 1'b1;
          if (is_slash || is_digit || is_word_start) token_start <= byte_offset;
          if (is_slash) held_slash_line <= line_count;
          if (is_word_start) ident_len <= skl_pkg::KW_LEN_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !is_end) begin
      if (cont && mode == skl_pkg::MODE_IDENT &&
          ident_len < skl_pkg::KW_LEN_BITS'(skl_pkg::MAX_KW_LEN))
        prefix_store[ident_len[skl_pkg::KW_IDX_BITS-1:0]] <= c;
      if (restart && is_word_start) prefix_store[0] <= c;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (push_one) fifo_mem[wr_ptr] <= fin_valid ? fin_tok : b_tok;
    if (push_two) fifo_mem[wr_ptr + 1'b1] <= b_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      wr_ptr   <= wr_ptr + skl_pkg::FIFO_PTR_BITS'(push_one) +
                  skl_pkg::FIFO_PTR_BITS'(push_two);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fifo_cnt <= fifo_cnt + skl_pkg::FIFO_CNT_BITS'(push_one) +
                  skl_pkg::FIFO_CNT_BITS'(push_two) - skl_pkg::FIFO_CNT_BITS'(pop);
    end
  end

  assign src.ready        = fifo_cnt <= skl_pkg::FIFO_CNT_BITS'(skl_pkg::FIFO_DEPTH - 2);
  assign tok.valid        = fifo_cnt != '0;
  assign tok.token_kind   = fifo_mem[rd_ptr].kind;
  assign tok.start_offset = fifo_mem[rd_ptr].start;
  assign tok.token_length = fifo_mem[rd_ptr].length;
  assign tok.line_number  = fifo_mem[rd_ptr].line;
  assign tok.byte_value   = fifo_mem[rd_ptr].bval;
  assign tok.run_end      = fifo_mem[rd_ptr].run_end;

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= skl_pkg::FIFO_CNT_BITS'(skl_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    take && is_end |=> mode == skl_pkg::MODE_IDLE)
    else $error("scan not idle after end marker");

  a_ident_len: assert property (@(posedge clk) disable iff (rst)
    ident_len <= skl_pkg::KW_LEN_BITS'(skl_pkg::MAX_KW_LEN + 1))
    else $error("identifier length past saturation");

  a_slash_line: assert property (@(posedge clk) disable iff (rst)
    mode == skl_pkg::MODE_SLASH |-> held_slash_line == line_count)
    else $error("held slash line out of step");

  a_end_eof: assert property (@(posedge clk) disable iff (rst)
    take && is_end |-> b_valid && push_one)
    else $error("end marker without eof token");

endmodule
